### rtl/wpk_pkg.sv
// ----------------------------------------------------------------------------
// wpk_pkg: shared types and constants of the window peak keyframe picker
// Field widths, register map and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package wpk_pkg;

   localparam int SCORE_W = 16;   // score and clarity, unsigned Q1.15
   localparam int IDX_W   = 24;   // global frame index
   localparam int AREA_W  = 21;   // area threshold width
   localparam int CSR_AW  = 3;    // configuration address width
   localparam int CSR_DW  = 32;   // configuration data width

   localparam logic [SCORE_W-1:0] PEAK_THR_RESET = 16'd1638;
   localparam logic [AREA_W-1:0]  AREA_THR_RESET = 21'd5243;

   // Register select bit of the configuration address (paddr[2])
   localparam logic REG_PEAK = 1'b0;
   localparam logic REG_AREA = 1'b1;

   typedef struct packed {
      logic load;        // write the accepted transaction into the stores
      logic scan_start;  // arm a max search over the loaded window
      logic scan_run;    // step the max search
      logic span_start;  // arm a pass over the span around the peak
      logic span_run;    // step the span pass (sum, clarity, zero)
      logic emit_key;    // place a keyframe result in the output register
      logic emit_done;   // place the done marker, advance the window base
   } cmd_type;

   typedef struct packed {
      logic close;       // the offered transaction closes the window
      logic busy;        // a search or span pass is still in flight
      logic stop;        // the found peak ends the window
      logic want_emit;   // the span passed the area test and has a clear frame
      logic out_free;    // the output register can take a result
   } sts_type;

endpackage

### rtl/wpk_ctrl.sv
// ----------------------------------------------------------------------------
// wpk_ctrl: sequencer of the window peak keyframe picker
// Steps through load, max search, peak test, span pass and result emission.
// ----------------------------------------------------------------------------
module wpk_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  wpk_pkg::sts_type sts,
   output wpk_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_JUDGE = 3'd2;
   localparam logic [2:0] ST_SPAN  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (req_tvalid && sts.close) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (!sts.busy) begin
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            if (sts.stop) begin
               state_in = ST_DONE;
            end else begin
               cmd.span_start = 1'b1;
               state_in       = ST_SPAN;
            end
         end
         ST_SPAN: begin
            cmd.span_run = 1'b1;
            if (!sts.busy) begin
               if (sts.want_emit) begin
                  state_in = ST_EMIT;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_key   = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.emit_done = 1'b1;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/wpk_dp.sv
// ----------------------------------------------------------------------------
// wpk_dp: datapath of the window peak keyframe picker
// Score and clarity stores, address sequencing, max search, span sum,
// clarity search, span zeroing and the result register.
// ----------------------------------------------------------------------------
module wpk_dp #(
   parameter int WINDOW_LEN = 64,
   parameter int SPACING    = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  wpk_pkg::cmd_type                cmd,
   output wpk_pkg::sts_type                sts,
   input  logic [2*wpk_pkg::SCORE_W-1:0]   req_tdata,
   input  logic                            req_tlast,
   input  logic [wpk_pkg::SCORE_W-1:0]     peak_thr,
   input  logic [wpk_pkg::AREA_W-1:0]      area_thr,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [wpk_pkg::IDX_W-1:0]       rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int SW    = wpk_pkg::SCORE_W;
   localparam int AW    = $clog2(WINDOW_LEN);
   localparam int SUM_W = SW + $clog2(2 * SPACING + 2);
   localparam int CMP_W = (SUM_W > wpk_pkg::AREA_W) ? SUM_W : wpk_pkg::AREA_W;

   logic [SW-1:0] score_mem [WINDOW_LEN];
   logic [SW-1:0] clar_mem  [WINDOW_LEN];
   logic [SW-1:0] score_rd_ff;
   logic [SW-1:0] clar_rd_ff;

   logic [AW-1:0]    pos_ff,   pos_in;
   logic [AW-1:0]    last_ff,  last_in;
   logic [AW-1:0]    end_ff,   end_in;
   logic [AW-1:0]    addr_ff,  addr_in;
   logic             iss_ff,   iss_in;
   logic             rdv_ff,   rdv_in;
   logic [AW-1:0]    ridx_ff,  ridx_in;
   logic [SW-1:0]    best_ff,  best_in;
   logic [AW-1:0]    peak_ff,  peak_in;
   logic [SUM_W-1:0] sum_ff,   sum_in;
   logic [SW-1:0]    cbest_ff, cbest_in;
   logic [AW-1:0]    cidx_ff,  cidx_in;
   logic [wpk_pkg::IDX_W-1:0] base_ff, base_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [wpk_pkg::IDX_W-1:0] rsp_idx_ff,   rsp_idx_in;
   logic                      rsp_key_ff,   rsp_key_in;
   logic                      rsp_done_ff,  rsp_done_in;

   logic              run;
   logic              issue;
   logic              score_we;
   logic [AW-1:0]     score_wa;
   logic [SW-1:0]     score_wd;
   logic [AW:0]       peak_x;
   logic [AW:0]       hi_x;
   logic [AW-1:0]     span_lo;
   logic [AW-1:0]     span_hi;

   assign run   = cmd.scan_run | cmd.span_run;
   assign issue = run & iss_ff;

   // Zero each span entry as it is read; the read returns the old value
   assign score_we = cmd.load | (cmd.span_run & iss_ff);
   assign score_wa = cmd.load ? pos_ff : addr_ff;
   assign score_wd = cmd.load ? req_tdata[SW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (score_we) begin
         score_mem[score_wa] <= score_wd;
      end
      score_rd_ff <= score_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         clar_mem[pos_ff] <= req_tdata[2*SW-1:SW];
      end
      clar_rd_ff <= clar_mem[addr_ff];
   end

   // Span bounds around the peak, clipped to the loaded window
   assign peak_x  = {1'b0, peak_ff};
   assign hi_x    = peak_x + (AW+1)'(SPACING);
   assign span_lo = (peak_x >= (AW+1)'(SPACING)) ? AW'(peak_x - (AW+1)'(SPACING)) : '0;
   assign span_hi = (hi_x > {1'b0, last_ff}) ? last_ff : hi_x[AW-1:0];

   assign sts.close     = req_tlast || (pos_ff == AW'(WINDOW_LEN - 1));
   assign sts.busy      = iss_ff | rdv_ff;
   assign sts.stop      = (best_ff == '0) || (best_ff < peak_thr);
   assign sts.want_emit = (CMP_W'(sum_ff) > CMP_W'(area_thr)) && (cbest_ff != '0);
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      pos_in   = pos_ff;
      last_in  = last_ff;
      end_in   = end_ff;
      addr_in  = addr_ff;
      iss_in   = iss_ff;
      rdv_in   = issue;
      ridx_in  = addr_ff;
      best_in  = best_ff;
      peak_in  = peak_ff;
      sum_in   = sum_ff;
      cbest_in = cbest_ff;
      cidx_in  = cidx_ff;
      base_in  = base_ff;

      if (cmd.load) begin
         if (sts.close) begin
            last_in = pos_ff;
         end else begin
            pos_in = pos_ff + AW'(1);
         end
      end

      // Address sequencing for both passes
      if (issue) begin
         addr_in = addr_ff + AW'(1);
         if (addr_ff == end_ff) begin
            iss_in = 1'b0;
         end
      end
      if (cmd.scan_start) begin
         addr_in = '0;
         end_in  = last_in;
         iss_in  = 1'b1;
         best_in = '0;
         peak_in = '0;
      end
      if (cmd.span_start) begin
         addr_in  = span_lo;
         end_in   = span_hi;
         iss_in   = 1'b1;
         sum_in   = '0;
         cbest_in = '0;
      end

      // Keep the first position of the largest value
      if (cmd.scan_run && rdv_ff && (score_rd_ff > best_ff)) begin
         best_in = score_rd_ff;
         peak_in = ridx_ff;
      end
      if (cmd.span_run && rdv_ff) begin
         sum_in = sum_ff + SUM_W'(score_rd_ff);
         if (clar_rd_ff > cbest_ff) begin
            cbest_in = clar_rd_ff;
            cidx_in  = ridx_ff;
         end
      end

      if (cmd.emit_done) begin
         pos_in  = '0;
         base_in = base_ff + wpk_pkg::IDX_W'(WINDOW_LEN);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_done_in  = rsp_done_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit_key) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = base_ff + wpk_pkg::IDX_W'(cidx_ff);
         rsp_key_in   = 1'b1;
         rsp_done_in  = 1'b0;
      end
      if (cmd.emit_done) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = '0;
         rsp_key_in   = 1'b0;
         rsp_done_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         base_ff      <= '0;
         iss_ff       <= 1'b0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         base_ff      <= base_in;
         iss_ff       <= iss_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      end_ff      <= end_in;
      addr_ff     <= addr_in;
      ridx_ff     <= ridx_in;
      best_ff     <= best_in;
      peak_ff     <= peak_in;
      sum_ff      <= sum_in;
      cbest_ff    <= cbest_in;
      cidx_ff     <= cidx_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_idx_ff;
   assign rsp_tuser  = rsp_key_ff;
   assign rsp_tlast  = rsp_done_ff;

endmodule

### rtl/window_peak_keyframe_picker_unit.sv
// Loading: one transaction per cycle in the load state; after the close each peak takes a
//   max search over the n loaded positions and a span pass (span <= 2*SPACING+1), both
//   through the single score store read port; a final search precedes the done marker.
// Throughput: one window at a time; no transaction is taken until the done marker is placed.
// Reset: synchronous, active high; clears control, load position, window base and result
//   valid, restores both thresholds; the stores keep their contents.
// ----------------------------------------------------------------------------
// window_peak_keyframe_picker_unit: keyframe picker with peak suppression
// Loads a window of score/clarity pairs, then repeatedly takes the strongest
// peak, tests the span around it and reports the clearest frame of the span.
// ----------------------------------------------------------------------------
module window_peak_keyframe_picker_unit #(
   parameter int WINDOW_LEN = 64,   // positions per window, 17 to 1024
   parameter int SPACING    = 8     // half-width of the suppression span, 1 to 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,   // [15:0] score, [31:16] clarity
   input  logic                          req_tlast,   // last_in_window
   // Result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [23:0]                   rsp_tdata,   // [23:0] keyframe_index
   output logic                          rsp_tuser,   // [0] has_keyframe
   output logic                          rsp_tlast,   // window_done
   // Configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [wpk_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [wpk_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [wpk_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);

   wpk_pkg::cmd_type cmd;
   wpk_pkg::sts_type sts;

   logic [wpk_pkg::SCORE_W-1:0] peak_thr_ff, peak_thr_in;
   logic [wpk_pkg::AREA_W-1:0]  area_thr_ff, area_thr_in;
   logic                        csr_wr;

   // Configuration registers: decode on the word select bit only
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      peak_thr_in = peak_thr_ff;
      area_thr_in = area_thr_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            wpk_pkg::REG_PEAK: peak_thr_in = csr_pwdata[wpk_pkg::SCORE_W-1:0];
            wpk_pkg::REG_AREA: area_thr_in = csr_pwdata[wpk_pkg::AREA_W-1:0];
            default: begin
               peak_thr_in = peak_thr_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         wpk_pkg::REG_PEAK: csr_prdata = wpk_pkg::CSR_DW'(peak_thr_ff);
         wpk_pkg::REG_AREA: csr_prdata = wpk_pkg::CSR_DW'(area_thr_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_thr_ff <= wpk_pkg::PEAK_THR_RESET;
         area_thr_ff <= wpk_pkg::AREA_THR_RESET;
      end else begin
         peak_thr_ff <= peak_thr_in;
         area_thr_ff <= area_thr_in;
      end
   end

   // Sequencer: owns the handshake on the input side
   wpk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Stores, search logic and the result register
   wpk_dp #(
      .WINDOW_LEN (WINDOW_LEN),
      .SPACING    (SPACING)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .peak_thr   (peak_thr_ff),
      .area_thr   (area_thr_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   // A result is either a keyframe or the done marker, never both or neither
   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot({rsp_tuser, rsp_tlast}))
      else $error("result is not exactly one of keyframe and done marker");

   // The done marker carries a zero index
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata == '0))
      else $error("done marker carries a nonzero index");

   // Reset drops any pending result
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // No transaction is taken during a max search, a span pass or a keyframe emission
   a_no_load_in_search: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !(cmd.scan_run || cmd.span_run || cmd.emit_key))
      else $error("input taken during search");
`endif

endmodule
